[hw/rtl/trc_pkg.sv]
// Shared types and constants of the time-of-flight report collector.
`timescale 1ns / 1ps
package trc_pkg;

	localparam int WORD_W     = 16;
	localparam int CODE_W     = 15;
	localparam int CNT_W      = 16;
	localparam int REF_W      = 3;
	localparam int TOF_W      = 12;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] CFG_START_CODE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_GATE_DELAY = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LEN = 2'd2;

	localparam logic [CODE_W-1:0] START_CODE_RST = 15'd1;
	localparam logic [CNT_W-1:0]  GATE_DELAY_RST = 16'd50000;
	localparam logic [CNT_W-1:0]  WINDOW_LEN_RST = 16'd59000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GATE,
		ST_LOG,
		ST_DUMP
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic clear_slots; // zero all slots
		logic cnt_zero;    // restart the tick counter at zero
		logic cnt_step;    // load the incremented count
		logic write_slot;  // store the flight time of the current word
		logic dump_start;  // reset the dump index
		logic load_out;    // load the next slot into the output register
	} ctl_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic is_tick;   // current item is a tick
		logic word_ok;   // word passes parity and is nonzero
		logic is_start;  // word equals the start code
		logic gate_hit;  // incremented count equals gate_delay
		logic win_hit;   // incremented count equals window_len
		logic out_free;  // output register can take a result this cycle
		logic dump_last; // dump index points at the final slot
	} dp_status_t;

endpackage

[hw/rtl/trc_ctrl.sv]
// Controller state machine of the time-of-flight report collector.
`timescale 1ns / 1ps
module trc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  trc_pkg::dp_status_t status,
	output trc_pkg::ctl_cmd_t  cmd
);

	trc_pkg::state_t state_q;
	trc_pkg::state_t state_d;
	logic            accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q != trc_pkg::ST_DUMP);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			trc_pkg::ST_DUMP: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					if (status.dump_last) begin
						state_d = trc_pkg::ST_IDLE;
					end
				end
			end
			trc_pkg::ST_IDLE, trc_pkg::ST_GATE, trc_pkg::ST_LOG: begin
				if (accept && !status.is_tick) begin
					if (status.word_ok && status.is_start) begin
						cmd.clear_slots = 1'b1;
						cmd.cnt_zero    = 1'b1;
						state_d         = trc_pkg::ST_GATE;
					end else if (status.word_ok && state_q == trc_pkg::ST_LOG) begin
						cmd.write_slot = 1'b1;
					end
				end else if (accept && state_q == trc_pkg::ST_GATE) begin
					if (status.gate_hit) begin
						cmd.cnt_zero = 1'b1;
						if (status.win_hit) begin
							cmd.dump_start = 1'b1;
							state_d        = trc_pkg::ST_DUMP;
						end else begin
							state_d = trc_pkg::ST_LOG;
						end
					end else begin
						cmd.cnt_step = 1'b1;
					end
				end else if (accept && state_q == trc_pkg::ST_LOG) begin
					cmd.cnt_step = 1'b1;
					if (status.win_hit) begin
						cmd.dump_start = 1'b1;
						state_d        = trc_pkg::ST_DUMP;
					end
				end
			end
			default: begin
				state_d = trc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/trc_datapath.sv]
// Datapath of the time-of-flight report collector: registers, counter, slots, output.
`timescale 1ns / 1ps
module trc_datapath #(
	parameter int NUM_REFS = 8,
	parameter int TOF_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [trc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [trc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              func,
	input  logic [trc_pkg::WORD_W-1:0]        word,
	input  trc_pkg::ctl_cmd_t                 cmd,
	output trc_pkg::dp_status_t               status,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [trc_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tlast
);

	localparam int IDX_W = $clog2(NUM_REFS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_REFS - 1);

	logic [trc_pkg::CODE_W-1:0] start_code_q;
	logic [trc_pkg::CNT_W-1:0]  gate_delay_q;
	logic [trc_pkg::CNT_W-1:0]  window_len_q;
	logic [trc_pkg::CNT_W-1:0]  tick_q;
	logic [trc_pkg::CNT_W-1:0]  tick_next;
	logic [TOF_BITS-1:0]        slots_q [NUM_REFS];
	logic [IDX_W-1:0]           dump_idx_q;
	logic                       out_valid_q;
	logic [trc_pkg::REF_W-1:0]  out_ref_q;
	logic [trc_pkg::TOF_W-1:0]  out_tof_q;
	logic                       out_last_q;
	logic [trc_pkg::CODE_W-1:0] code;
	logic [trc_pkg::REF_W-1:0]  ref_sel;
	logic                       ref_ok;

	assign code      = word[trc_pkg::CODE_W-1:0];
	assign ref_sel   = word[14:12];
	assign ref_ok    = (32'(ref_sel) < NUM_REFS);
	assign tick_next = tick_q + 16'd1;

	always_comb begin
		status.is_tick   = func;
		status.word_ok   = (code != '0) && ((^code) == word[15]);
		status.is_start  = (code == start_code_q);
		status.gate_hit  = (tick_next == gate_delay_q);
		status.win_hit   = (tick_next == window_len_q);
		status.out_free  = !out_valid_q || m_tready;
		status.dump_last = (dump_idx_q == LAST_IDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= trc_pkg::START_CODE_RST;
			gate_delay_q <= trc_pkg::GATE_DELAY_RST;
			window_len_q <= trc_pkg::WINDOW_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				trc_pkg::CFG_START_CODE: start_code_q <= cfg_data[trc_pkg::CODE_W-1:0];
				trc_pkg::CFG_GATE_DELAY: gate_delay_q <= cfg_data;
				trc_pkg::CFG_WINDOW_LEN: window_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (cmd.cnt_zero) begin
			tick_q <= '0;
		end else if (cmd.cnt_step) begin
			tick_q <= tick_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REFS; i++) begin
				slots_q[i] <= '0;
			end
		end else if (cmd.clear_slots) begin
			for (int i = 0; i < NUM_REFS; i++) begin
				slots_q[i] <= '0;
			end
		end else if (cmd.write_slot && ref_ok) begin
			slots_q[ref_sel[IDX_W-1:0]] <= word[TOF_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dump_idx_q <= '0;
		end else if (cmd.dump_start) begin
			dump_idx_q <= '0;
		end else if (cmd.load_out && !status.dump_last) begin
			dump_idx_q <= dump_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_ref_q  <= trc_pkg::REF_W'(dump_idx_q);
			out_tof_q  <= trc_pkg::TOF_W'(slots_q[dump_idx_q]);
			out_last_q <= status.dump_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_tof_q, out_ref_q};
	assign m_tlast  = out_last_q;

endmodule

[hw/rtl/tof_report_collector_core.sv]
// Top level of the time-of-flight report collector.
`timescale 1ns / 1ps
// Dump: a tick that closes the window moves the controller into the dump state, which
//   loads one slot a cycle into the output register as the sink takes them.
// Throughput: one input request per cycle outside a dump; a dump holds the input until
//   its last slot is loaded.
// Reset (arst_n low, asynchronous): idle, counter and slots zero, registers at defaults.
module tof_report_collector_core #(
	parameter int NUM_REFS = 8,
	parameter int TOF_BITS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port.
	input  logic                           cfg_we,
	input  logic [trc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [trc_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [trc_pkg::WORD_W-1:0]     s_tdata,  // [15:0] word
	input  logic                           s_tuser,  // [0] func: 1 = tick, 0 = word
	// Result stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [trc_pkg::OUT_DATA_W-1:0] m_tdata,  // [2:0] ref_index, [14:3] flight_time
	output logic                           m_tlast
);

	trc_pkg::ctl_cmd_t   cmd;
	trc_pkg::dp_status_t status;

	// Sequence start, gate, logging and dump; hold input during a dump.
	trc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Check words, count ticks, store slots and drive the result register.
	trc_datapath #(
		.NUM_REFS (NUM_REFS),
		.TOF_BITS (TOF_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.func     (s_tuser),
		.word     (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the time-of-flight report collector core.
`timescale 1ns / 1ps
module tb_top;
	import trc_pkg::*;

	localparam int NUM_REFS      = 8;
	localparam int TOF_BITS      = 12;
	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 9;
	localparam int RAND_REQS     = 140;   // random requests before the stimulus stops
	localparam int TAIL_REQS     = 30;    // last random requests run without idling
	localparam int ROUND_REQS    = 40;    // random requests between register changes
	localparam int CYCLE_CAP     = 60;    // requests allowed in one measurement cycle
	localparam int DRAIN_LIMIT   = 5000;  // cycles to wait for outstanding reports
	localparam int SETTLE_CYCLES = 4;     // settle after a drain, before a register write
	localparam int MAX_REPORTS   = 10;

	localparam logic FUNC_WORD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// One slot of a dump, as the core should present it.
	typedef struct packed {
		logic [REF_W-1:0] ref_index;
		logic [TOF_W-1:0] flight_time;
		logic             last;
	} slot_report_t;

	// How a row of the directed plan is checked.
	typedef enum logic [1:0] {
		ROW_PREDICT,   // expectations come from the predictor
		ROW_QUIET,     // typed: no report at all
		ROW_ZERO_DUMP, // typed: a full dump of empty slots
		ROW_CFG        // register write, taken once owed reports are out
	} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic                  func;
		logic [CFG_ADDR_W-1:0] reg_idx;
		logic [WORD_W-1:0]     value;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [WORD_W-1:0]     s_tdata;   // [15:0] word
	logic                  s_tuser;   // [0] func
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // [2:0] ref_index, [14:3] flight_time
	logic                  m_tlast;

	// Predictor copy of the registers and of the collector state.
	logic [CODE_W-1:0] code_reg;
	logic [CNT_W-1:0]  gate_reg;
	logic [CNT_W-1:0]  win_reg;
	state_t            tof_phase;
	logic [CNT_W-1:0]  tick_cnt;
	logic [TOF_W-1:0]  slot_tof [NUM_REFS];

	// Slot reports still owed by the core, oldest first.
	slot_report_t report_q [$];

	int mismatches = 0;
	bit idle_en    = 1'b1;
	bit stall_en   = 1'b1;
	int stall_left = 0;

	tof_report_collector_core #(
		.NUM_REFS(NUM_REFS),
		.TOF_BITS(TOF_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// Attach the parity bit: bit 15 is the XOR of the fifteen low bits.
	function automatic logic [WORD_W-1:0] par_word(input logic [CODE_W-1:0] v);
		return {^v, v};
	endfunction

	// Radio word with good parity, a random reference and flight time, extremes favored.
	function automatic logic [WORD_W-1:0] random_word();
		logic [REF_W-1:0] ref_no;
		logic [TOF_W-1:0] tof;
		ref_no = REF_W'($urandom_range(0, NUM_REFS - 1));
		case ($urandom_range(0, 7))
			0: tof = '0;
			1: tof = '1;
			default: tof = TOF_W'($urandom_range(0, 4095));
		endcase
		return par_word({ref_no, tof});
	endfunction

	function automatic stim_row_t item_row(input row_kind_t kind, input logic func,
			input logic [WORD_W-1:0] word);
		stim_row_t r;
		r.kind    = kind;
		r.func    = func;
		r.reg_idx = CFG_START_CODE;
		r.value   = word;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_ADDR_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r.kind    = ROW_CFG;
		r.func    = FUNC_WORD;
		r.reg_idx = idx;
		r.value   = data;
		return r;
	endfunction

	// Advance the predictor by one accepted request; queue the dump when post is set.
	task automatic predict_request(input logic func, input logic [WORD_W-1:0] word,
			input bit post);
		logic [CODE_W-1:0] v;
		logic [CNT_W-1:0]  c;
		v = word[CODE_W-1:0];
		if (func == FUNC_WORD) begin
			// Rejected words (zero payload or bad parity) leave everything alone.
			if (v != '0 && (^v) == word[WORD_W-1]) begin
				if (v == code_reg) begin
					// Start code: clear slots and restart the gate, even mid-cycle.
					foreach (slot_tof[i]) slot_tof[i] = '0;
					tof_phase = ST_GATE;
					tick_cnt  = '0;
				end else if (tof_phase == ST_LOG && int'(v[14:12]) < NUM_REFS) begin
					slot_tof[v[14:12]] = v[TOF_BITS-1:0];
				end
			end
		end else if (tof_phase != ST_IDLE) begin
			// Increment first, wrapping at 16 bits; idle ticks are dropped.
			c = tick_cnt + 1'b1;
			if (tof_phase == ST_GATE && c == gate_reg) begin
				tof_phase = ST_LOG;
				tick_cnt  = '0;
			end else begin
				tick_cnt = c;
			end
			// The same count may close the window on the tick that opened it.
			if (tof_phase == ST_LOG && c == win_reg) begin
				if (post) begin
					for (int i = 0; i < NUM_REFS; i++)
						report_q.push_back('{REF_W'(i), slot_tof[i], i == NUM_REFS - 1});
				end
				tof_phase = ST_IDLE;
			end
		end
	endtask

	// Offer one request, with an optional idle burst first; predict once it is taken.
	task automatic send_request(input logic func, input logic [WORD_W-1:0] word,
			input row_kind_t kind);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		predict_request(func, word, kind == ROW_PREDICT);
		if (kind == ROW_ZERO_DUMP) begin
			for (int i = 0; i < NUM_REFS; i++)
				report_q.push_back('{REF_W'(i), '0, i == NUM_REFS - 1});
		end
	endtask

	// Hold the sender until every owed report is out, then let the core settle.
	task automatic drain_reports(input int settle);
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (report_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (settle) @(posedge clk);
	endtask

	// Write one register once owed reports are out and mirror it in the predictor.
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		drain_reports(SETTLE_CYCLES);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_START_CODE: code_reg = data[CODE_W-1:0];
			CFG_GATE_DELAY: gate_reg = data;
			CFG_WINDOW_LEN: win_reg = data;
			default: ;
		endcase
	endtask

	// Result sink: random stall bursts, no new burst once stall_en drops.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (stall_en && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 12);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare every accepted report against the oldest expectation, field by field.
	always @(posedge clk) begin : report_check
		slot_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (report_q.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected report: ref=%0d tof=%03h last=%0b",
						m_tdata[REF_W-1:0], m_tdata[REF_W+TOF_W-1:REF_W], m_tlast);
				mismatches++;
			end else begin
				want = report_q.pop_front();
				if (m_tdata[REF_W-1:0] !== want.ref_index
						|| m_tdata[REF_W+TOF_W-1:REF_W] !== want.flight_time
						|| m_tlast !== want.last) begin
					if (mismatches < MAX_REPORTS)
						$display("mismatch: want ref/tof/last %0d/%03h/%0b, got %0d/%03h/%0b",
							want.ref_index, want.flight_time, want.last,
							m_tdata[REF_W-1:0], m_tdata[REF_W+TOF_W-1:REF_W], m_tlast);
					mismatches++;
				end
			end
		end
	end

	initial begin
		stim_row_t         plan [$];
		int                rand_reqs;
		int                seg;
		int                steps;
		int                pick;
		logic [CNT_W-1:0]  gate_pick;
		logic [CNT_W-1:0]  win_pick;
		logic [CODE_W-1:0] code_pick;

		// Known values on every input from time zero; hold reset.
		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tuser  = FUNC_WORD;
		s_tdata  = '0;
		m_tready = 1'b0;

		code_reg  = START_CODE_RST;
		gate_reg  = GATE_DELAY_RST;
		win_reg   = WINDOW_LEN_RST;
		tof_phase = ST_IDLE;
		tick_cnt  = '0;
		foreach (slot_tof[i]) slot_tof[i] = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed plan. Right after reset, nothing here may produce a report.
		plan.push_back(item_row(ROW_QUIET, FUNC_TICK, 16'h0000));  // tick while idle
		plan.push_back(item_row(ROW_QUIET, FUNC_WORD, 16'h0000));  // all-zero word
		plan.push_back(item_row(ROW_QUIET, FUNC_WORD, 16'h8000));  // zero payload, parity set
		plan.push_back(item_row(ROW_QUIET, FUNC_WORD, 16'h0001));  // start code, bad parity
		plan.push_back(item_row(ROW_QUIET, FUNC_TICK, 16'hFFFF));  // tick ignores its data
		// Equal delays: the tick that opens the window dumps it empty.
		plan.push_back(cfg_row(CFG_GATE_DELAY, 16'd1));
		plan.push_back(cfg_row(CFG_WINDOW_LEN, 16'd1));
		plan.push_back(item_row(ROW_QUIET, FUNC_WORD, 16'h8001));  // default start code
		plan.push_back(item_row(ROW_ZERO_DUMP, FUNC_TICK, 16'h0000));
		// Two-tick window: words in gate are dropped, in log stored, last write wins.
		plan.push_back(cfg_row(CFG_WINDOW_LEN, 16'd2));
		plan.push_back(item_row(ROW_QUIET, FUNC_WORD, 16'h8001));
		plan.push_back(item_row(ROW_PREDICT, FUNC_WORD, par_word(15'h3ABC)));
		plan.push_back(item_row(ROW_PREDICT, FUNC_TICK, 16'h0000));
		plan.push_back(item_row(ROW_PREDICT, FUNC_WORD, par_word(15'h0FFF)));
		plan.push_back(item_row(ROW_PREDICT, FUNC_WORD, par_word(15'h7001)));
		plan.push_back(item_row(ROW_PREDICT, FUNC_WORD, par_word(15'h5555) ^ 16'h8000));
		plan.push_back(item_row(ROW_PREDICT, FUNC_WORD, par_word(15'h0123)));
		plan.push_back(item_row(ROW_PREDICT, FUNC_TICK, 16'h0000));
		// Largest start code; the old code is now a plain word stored in the open window.
		plan.push_back(cfg_row(CFG_START_CODE, 16'h7FFF));
		plan.push_back(item_row(ROW_QUIET, FUNC_WORD, 16'h8001));
		plan.push_back(item_row(ROW_QUIET, FUNC_WORD, 16'hFFFF));
		plan.push_back(item_row(ROW_QUIET, FUNC_TICK, 16'h0000));
		plan.push_back(item_row(ROW_PREDICT, FUNC_WORD, par_word(15'h6FFF)));
		// Start code inside the window: slots cleared, cycle restarts from gate.
		plan.push_back(item_row(ROW_QUIET, FUNC_WORD, 16'hFFFF));
		plan.push_back(item_row(ROW_QUIET, FUNC_TICK, 16'h0000));
		plan.push_back(item_row(ROW_QUIET, FUNC_TICK, 16'h0000));
		plan.push_back(item_row(ROW_ZERO_DUMP, FUNC_TICK, 16'h0000));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_reg(plan[i].reg_idx, plan[i].value);
			else
				send_request(plan[i].func, plan[i].value, plan[i].kind);
		end

		// Random part: short gates and windows, mostly full measurement cycles
		// with random words, some rejected words and restarts mixed in.
		rand_reqs = 0;
		while (rand_reqs < RAND_REQS) begin
			pick = $urandom_range(0, 3);
			if (pick == 0)
				code_pick = 15'd1;
			else if (pick == 1)
				code_pick = 15'h7FFF;
			else
				code_pick = CODE_W'($urandom_range(1, 32767));
			gate_pick = CNT_W'($urandom_range(1, 6));
			win_pick  = ($urandom_range(0, 3) == 0) ? gate_pick : CNT_W'($urandom_range(1, 10));
			write_reg(CFG_START_CODE, CFG_DATA_W'(code_pick));
			write_reg(CFG_GATE_DELAY, gate_pick);
			write_reg(CFG_WINDOW_LEN, win_pick);

			seg = 0;
			while (seg < ROUND_REQS && rand_reqs < RAND_REQS) begin
				// Idle noise first; the core should drop it.
				repeat ($urandom_range(0, 2)) begin
					if ($urandom_range(0, 1) == 0)
						send_request(FUNC_TICK, WORD_W'($urandom_range(0, 65535)), ROW_PREDICT);
					else
						send_request(FUNC_WORD, random_word(), ROW_PREDICT);
				end

				send_request(FUNC_WORD, par_word(code_reg), ROW_PREDICT);
				steps = 0;
				while (tof_phase != ST_IDLE && steps < CYCLE_CAP) begin
					pick = $urandom_range(0, 99);
					if (pick < 50)
						send_request(FUNC_TICK, WORD_W'($urandom_range(0, 65535)), ROW_PREDICT);
					else if (pick < 80)
						send_request(FUNC_WORD, random_word(), ROW_PREDICT);
					else if (pick < 88)
						send_request(FUNC_WORD,
							par_word(CODE_W'($urandom_range(1, 32767))) ^ 16'h8000, ROW_PREDICT);
					else if (pick < 92)
						send_request(FUNC_WORD, {1'($urandom_range(0, 1)), 15'h0000}, ROW_PREDICT);
					else if (pick < 95)
						send_request(FUNC_WORD, par_word(code_reg), ROW_PREDICT);
					else
						send_request(FUNC_WORD, WORD_W'($urandom_range(0, 65535)), ROW_PREDICT);
					steps++;
				end
				seg       += steps + 1;
				rand_reqs += steps + 1;

				// Quiet tail: no idling on either side for the last requests.
				if (rand_reqs >= RAND_REQS - TAIL_REQS) begin
					idle_en  = 1'b0;
					stall_en = 1'b0;
				end
				// Now and then hold the sender until the sink has caught up.
				if ($urandom_range(0, 3) == 0)
					drain_reports(0);
			end
		end

		idle_en  = 1'b0;
		stall_en = 1'b0;
		drain_reports(2 * SETTLE_CYCLES);
		if (report_q.size() != 0) begin
			$display("%0d reports never arrived", report_q.size());
			mismatches += report_q.size();
		end

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Timeout guard, well beyond the slowest legal run.
	initial begin
		#(10_000_000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
